// File: src/dvf_pkg.sv
package dvf_pkg;

    // Request codes carried on the item's type field
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_LEVEL  = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_END    = 2'd3
    } t_req;

    // Width of the vertex fields on the ports
    localparam int unsigned VERTEX_PORT_W = 32;

endpackage

// File: src/dvf_tag_ram.sv
module dvf_tag_ram #(
    parameter int unsigned DEPTH_BITS = 14,
    parameter int unsigned WIDTH      = 72
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [DEPTH_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]      o_rd_data,
    input  logic                  i_wr_en,
    input  logic [DEPTH_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]      i_wr_data
);

    localparam int unsigned DEPTH = 1 << DEPTH_BITS;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/dvf_way_match.sv
module dvf_way_match #(
    parameter int unsigned NUM_WAYS = 4,
    parameter int unsigned TAG_W    = 18,
    parameter int unsigned PTR_W    = 2
) (
    input  logic [NUM_WAYS*TAG_W-1:0] i_row,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic [PTR_W-1:0]          i_ptr,
    output logic                      o_hit,
    output logic [NUM_WAYS*TAG_W-1:0] o_new_row
);

    logic [NUM_WAYS-1:0] w_way_hit;

    // Compare the tag against every way of the set
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_way_hit[w] = (i_row[w*TAG_W +: TAG_W] == i_tag);
        end
    end

    assign o_hit = |w_way_hit;

    // Replace the way under the round-robin pointer
    always_comb begin
        o_new_row = i_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_ptr == PTR_W'(w)) begin
                o_new_row[w*TAG_W +: TAG_W] = i_tag;
            end
        end
    end

endmodule

// File: src/duplicate_vertex_filter_unit.sv
// Channel   Handshake            Ports
// --------  -------------------  ------------------------------------------
// item in   start & !busy        i_req_type, i_vertex_id
// result    o_valid (1 cycle)    o_out_vertex, o_end_of_level
//
// A vertex lookup holds busy until its compare is done: the set's row
// is read from the tag RAM at the accepting edge and compared and written
// back in the next cycle, so no new item is taken while it is compared;
// its result strobes in the cycle after that. Start of level and end of level
// leave busy low. Start of search, and reset, clear the tag RAM, one row a
// cycle (2**INDEX_BITS rows, 16384 by default), with busy high.
// The receiver cannot stall: each result is on the ports for one cycle only.
module duplicate_vertex_filter_unit #(
    parameter int unsigned INDEX_BITS  = 14,
    parameter int unsigned VERTEX_BITS = 32,
    parameter int unsigned NUM_WAYS    = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_req_type,
    input  logic [dvf_pkg::VERTEX_PORT_W-1:0] i_vertex_id,
    output logic                             o_valid,
    output logic [dvf_pkg::VERTEX_PORT_W-1:0] o_out_vertex,
    output logic                             o_end_of_level
);

    localparam int unsigned TAG_BITS = VERTEX_BITS - INDEX_BITS;
    localparam int unsigned TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int unsigned ROW_W    = NUM_WAYS * TAG_W;
    localparam int unsigned PTR_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam logic [PTR_W-1:0] LAST_WAY = PTR_W'(NUM_WAYS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP
    } t_state;

    t_state                            r_state, n_state;
    logic [PTR_W-1:0]                  r_ptr, n_ptr;
    logic [INDEX_BITS-1:0]             r_clr_addr, n_clr_addr;
    logic                              r_valid, n_valid;
    logic                              r_eol, n_eol;
    logic [dvf_pkg::VERTEX_PORT_W-1:0] r_out, n_out;
    logic [INDEX_BITS-1:0]             r_set;
    logic [TAG_W-1:0]                  r_tag;
    logic [VERTEX_BITS-1:0]            r_vid;

    logic                   w_accept;
    dvf_pkg::t_req          w_req;
    logic [VERTEX_BITS-1:0] w_vid;
    logic [INDEX_BITS-1:0]  w_set;
    logic [TAG_W-1:0]       w_tag;
    logic                   w_rd_en;
    logic [ROW_W-1:0]       w_rd_row;
    logic                   w_wr_en;
    logic [INDEX_BITS-1:0]  w_wr_addr;
    logic [ROW_W-1:0]       w_wr_row;
    logic                   w_hit;
    logic [ROW_W-1:0]       w_new_row;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_req    = dvf_pkg::t_req'(i_req_type);

    // Split the id into set index and tag
    assign w_vid = i_vertex_id[VERTEX_BITS-1:0];
    assign w_set = w_vid[INDEX_BITS-1:0];

    generate
        if (TAG_BITS > 0) begin : g_tag
            assign w_tag = w_vid[VERTEX_BITS-1:INDEX_BITS];
        end else begin : g_no_tag
            // no tag bits: the id always equals the empty value
            assign w_tag = '1;
        end
    endgenerate

    dvf_tag_ram #(
        .DEPTH_BITS (INDEX_BITS),
        .WIDTH      (ROW_W)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_set),
        .o_rd_data (w_rd_row),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_row)
    );

    dvf_way_match #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W),
        .PTR_W    (PTR_W)
    ) u_way_match (
        .i_row     (w_rd_row),
        .i_tag     (r_tag),
        .i_ptr     (r_ptr),
        .o_hit     (w_hit),
        .o_new_row (w_new_row)
    );

    // Sequence clearing, lookup and write-back
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_clr_addr = r_clr_addr;
        n_valid    = 1'b0;
        n_eol      = 1'b0;
        n_out      = r_out;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_set;
        w_wr_row   = w_new_row;
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_row   = '1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        dvf_pkg::REQ_LOOKUP: begin
                            w_rd_en = 1'b1;
                            n_state = S_CMP;
                        end
                        dvf_pkg::REQ_LEVEL: begin
                            n_ptr = '0;
                        end
                        dvf_pkg::REQ_SEARCH: begin
                            n_ptr      = '0;
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        dvf_pkg::REQ_END: begin
                            n_valid = 1'b1;
                            n_eol   = 1'b1;
                            n_out   = '0;
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_state = S_IDLE;
                // drop on hit, else pass on and fill the pointed way
                if (!w_hit) begin
                    w_wr_en = 1'b1;
                    n_valid = 1'b1;
                    n_out   = dvf_pkg::VERTEX_PORT_W'(r_vid);
                    n_ptr   = (r_ptr == LAST_WAY) ? '0 : r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, pointer, item fields and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ptr      <= '0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
            r_eol      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
            r_eol      <= n_eol;
            r_out      <= n_out;
            if (w_accept) begin
                r_set <= w_set;
                r_tag <= w_tag;
                r_vid <= w_vid;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_end_of_level = r_eol;
    assign o_out_vertex   = r_out;

    // Pointer stays within the ways
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST_WAY)
        else $error("way pointer out of range");

    // End of level gives a zero marker in the next cycle
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == dvf_pkg::REQ_END)
        |=> (o_valid && o_end_of_level && o_out_vertex == '0))
        else $error("end-of-level marker missing");

    // A hit produces no result
    a_hit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && w_hit) |=> !o_valid)
        else $error("duplicate vertex passed on");

    // A miss produces a vertex result
    a_miss_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && !w_hit) |=> (o_valid && !o_end_of_level))
        else $error("first-seen vertex lost");

    // Start of search enters the clearing pass
    a_search_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == dvf_pkg::REQ_SEARCH) |=> (busy && r_clr_addr == '0))
        else $error("clearing pass not started");

endmodule
